### rtl/lcct_pkg.sv
// Shared widths, register indexes, reset values and the result record.
package lcct_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int EXP_W       = 15;
  localparam int WARM_W      = 4;
  localparam int SPACE_W     = 4;
  localparam int PIX_W       = 12;
  localparam int WAIT_W      = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPOSURE = 2'd0,
    REG_WARMUP   = 2'd1,
    REG_SPACING  = 2'd2,
    REG_PIXELS   = 2'd3
  } cfg_reg_t;

  localparam logic [EXP_W-1:0]   EXPOSURE_RST = EXP_W'(10);
  localparam logic [WARM_W-1:0]  WARMUP_RST   = WARM_W'(6);
  localparam logic [SPACE_W-1:0] SPACING_RST  = SPACE_W'(2);
  localparam logic [PIX_W-1:0]   PIXELS_RST   = PIX_W'(3694);

  typedef struct packed {
    logic [EXP_W-1:0]   exposure;
    logic [WARM_W-1:0]  warmup;
    logic [SPACE_W-1:0] spacing;
    logic [PIX_W-1:0]   pixels;
  } lcct_cfg_t;

  typedef struct packed {
    logic                   icg;
    logic                   sh;
    logic                   marker;
    logic                   pix_valid;
    logic [PIX_W-1:0]       pix_index;
    logic [SAMPLE_BITS-1:0] pix_value;
    logic                   done;
  } lcct_res_t;

endpackage

### rtl/linear_ccd_timing_capture.sv
// Top level: linear CCD gate/shutter timing generator with pixel capture.
//
// Usage:
//   in_*   request channel: in_action 0 is one timing tick, 1 is a converter
//          event carrying in_adc_sample. Every request yields exactly one
//          result on the out_* channel.
//   out_*  result channel: ICG, SH and trigger line levels after the request,
//          plus a captured pixel (valid, index, value) and an end-of-line flag.
//   cfg_*  register writes (index 0 exposure, 1 warmup pulses, 2 sample
//          spacing, 3 pixel count); always ready, write only while idle.
// The result of a request accepted at one edge is registered and is on out_*
//   right after it. Throughput is one request per cycle unless out_ready
//   stalls; the single result register and one pass of sequencer logic set it.
// Reset (rst_n low, synchronous) puts the sequencer at frame start with ICG
//   high, SH and trigger low, capture disarmed, and loads default registers.
// When the receiver stalls, the pending result holds and in_ready drops;
//   in_ready stays high while the waiting result is taken in the same cycle.
module linear_ccd_timing_capture import lcct_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_action,
  input  logic [SAMPLE_BITS-1:0] in_adc_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_icg_level,
  output logic                   out_sh_level,
  output logic                   out_frame_marker,
  output logic                   out_pixel_valid,
  output logic [PIX_W-1:0]       out_pixel_index,
  output logic [SAMPLE_BITS-1:0] out_pixel_value,
  output logic                   out_frame_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  lcct_cfg_t cfg_r;
  lcct_res_t res, res_r;
  logic      out_valid_r;
  logic      in_fire;

  // Accept a new request whenever the result slot is empty or being drained
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exposure <= EXPOSURE_RST;
      cfg_r.warmup   <= WARMUP_RST;
      cfg_r.spacing  <= SPACING_RST;
      cfg_r.pixels   <= PIXELS_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_EXPOSURE: cfg_r.exposure <= cfg_data[EXP_W-1:0];
        REG_WARMUP:   cfg_r.warmup   <= cfg_data[WARM_W-1:0];
        REG_SPACING:  cfg_r.spacing  <= cfg_data[SPACE_W-1:0];
        REG_PIXELS:   cfg_r.pixels   <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the sequencer once per accepted request
  lcct_frame_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .action     (in_action),
    .adc_sample (in_adc_sample),
    .cfg        (cfg_r),
    .res        (res)
  );

  // Result register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_icg_level    = res_r.icg;
  assign out_sh_level     = res_r.sh;
  assign out_frame_marker = res_r.marker;
  assign out_pixel_valid  = res_r.pix_valid;
  assign out_pixel_index  = res_r.pix_index;
  assign out_pixel_value  = res_r.pix_value;
  assign out_frame_done   = res_r.done;

endmodule

### rtl/lcct_frame_ctrl.sv
// Frame sequencer: gate/shutter timing state and pixel capture counters.
module lcct_frame_ctrl import lcct_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   action,
  input  logic [SAMPLE_BITS-1:0] adc_sample,
  input  lcct_cfg_t              cfg,
  output lcct_res_t              res
);

  typedef enum logic [3:0] {
    PH_START, PH_WARM_LOW, PH_WARM_HIGH, PH_PRE_INT, PH_INT_HIGH,
    PH_INT_LOW, PH_ARM_WAIT, PH_RD_A, PH_RD_B
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt, wait_inc;
  logic [PIX_W-1:0]   pulse_r, pulse_nxt, pulse_inc;
  logic               icg_r, icg_nxt, sh_r, sh_nxt, marker_r, marker_nxt;
  logic               armed_r, armed_nxt;
  logic [SPACE_W-1:0] elem_r, elem_nxt;
  logic [PIX_W-1:0]   pixcnt_r, pixcnt_nxt;
  logic [EXP_W-1:0]   eff_e;
  logic [EXP_W:0]     len;
  logic               hit;

  assign eff_e     = (cfg.exposure == '0) ? EXP_W'(1) : cfg.exposure;
  assign wait_inc  = wait_r + WAIT_W'(1);
  assign pulse_inc = pulse_r + PIX_W'(1);

  always_comb begin
    case (phase_r)
      PH_WARM_LOW, PH_RD_B: len = {eff_e, 1'b0};
      PH_PRE_INT:           len = {eff_e, 1'b0} - (EXP_W+1)'(1);
      PH_ARM_WAIT:          len = {1'b0, eff_e} - (EXP_W+1)'(1);
      PH_WARM_HIGH, PH_INT_HIGH, PH_INT_LOW, PH_RD_A: len = {1'b0, eff_e};
      default:              len = (EXP_W+1)'(1);
    endcase
  end

  assign hit = wait_inc >= {1'b0, len};

  always_comb begin
    phase_nxt  = phase_r;
    wait_nxt   = wait_r;
    pulse_nxt  = pulse_r;
    icg_nxt    = icg_r;
    sh_nxt     = sh_r;
    marker_nxt = marker_r;
    armed_nxt  = armed_r;
    elem_nxt   = elem_r;
    pixcnt_nxt = pixcnt_r;
    res        = '0;

    if (!action) begin
      wait_nxt = wait_inc;
      if (hit) begin
        wait_nxt = '0;
        case (phase_r)
          PH_WARM_LOW: begin
            sh_nxt    = 1'b1;
            phase_nxt = PH_WARM_HIGH;
          end
          PH_WARM_HIGH: begin
            sh_nxt    = 1'b0;
            pulse_nxt = pulse_inc;
            phase_nxt = (pulse_inc >= PIX_W'(cfg.warmup)) ? PH_PRE_INT : PH_WARM_LOW;
          end
          PH_PRE_INT: begin
            icg_nxt   = 1'b0;
            sh_nxt    = 1'b1;
            phase_nxt = PH_INT_HIGH;
          end
          PH_INT_HIGH: begin
            sh_nxt    = 1'b0;
            phase_nxt = PH_INT_LOW;
          end
          PH_INT_LOW, PH_ARM_WAIT: begin
            if (phase_r == PH_INT_LOW) begin
              icg_nxt    = 1'b1;
              armed_nxt  = 1'b1;
              pixcnt_nxt = '0;
              elem_nxt   = '0;
            end
            // Skip the arm wait when it is empty (E of one)
            if (phase_r == PH_INT_LOW && eff_e != EXP_W'(1)) begin
              phase_nxt = PH_ARM_WAIT;
            end else begin
              sh_nxt    = 1'b1;
              pulse_nxt = '0;
              if (cfg.pixels == '0) begin
                armed_nxt  = 1'b0;
                marker_nxt = 1'b0;
                phase_nxt  = PH_START;
              end else begin
                phase_nxt = PH_RD_A;
              end
            end
          end
          PH_RD_A: begin
            sh_nxt    = ~sh_r;
            phase_nxt = PH_RD_B;
          end
          PH_RD_B: begin
            sh_nxt    = ~sh_r;
            pulse_nxt = pulse_inc;
            if (pulse_inc >= cfg.pixels) begin
              armed_nxt  = 1'b0;
              marker_nxt = 1'b0;
              phase_nxt  = PH_START;
            end else begin
              phase_nxt = PH_RD_A;
            end
          end
          default: begin
            marker_nxt = 1'b1;
            icg_nxt    = 1'b1;
            pulse_nxt  = '0;
            phase_nxt  = (cfg.warmup != '0) ? PH_WARM_LOW : PH_PRE_INT;
          end
        endcase
      end
    end else if (armed_r) begin
      if (pixcnt_r >= cfg.pixels) begin
        armed_nxt  = 1'b0;
        marker_nxt = 1'b0;
        res.done   = 1'b1;
      end else if (elem_r == cfg.spacing) begin
        res.pix_valid = 1'b1;
        res.pix_index = pixcnt_r;
        res.pix_value = adc_sample;
        elem_nxt      = '0;
        pixcnt_nxt    = pixcnt_r + PIX_W'(1);
      end else begin
        elem_nxt = elem_r + SPACE_W'(1);
      end
    end

    res.icg    = icg_nxt;
    res.sh     = sh_nxt;
    res.marker = marker_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      wait_r   <= '0;
      pulse_r  <= '0;
      icg_r    <= 1'b1;
      sh_r     <= 1'b0;
      marker_r <= 1'b0;
      armed_r  <= 1'b0;
      elem_r   <= '0;
      pixcnt_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      wait_r   <= wait_nxt;
      pulse_r  <= pulse_nxt;
      icg_r    <= icg_nxt;
      sh_r     <= sh_nxt;
      marker_r <= marker_nxt;
      armed_r  <= armed_nxt;
      elem_r   <= elem_nxt;
      pixcnt_r <= pixcnt_nxt;
    end
  end

endmodule
